// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// Check that a signal is clear while reset is held
`define ASSERT_IN_RESET(label, clk, rstn, sig) \
    label: assert property (@(posedge clk) !rstn |=> !(sig)) \
        else $error("reset assertion failed");

`endif

// ===== hdl/rhnp_pkg.sv =====
// Package with constants and command/status types for the HSL palette block
package rhnp_pkg;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int PAL_CW = $clog2(PALETTE_ENTRIES + 1);
    localparam int ENTRY_W = 23;
    localparam int DIST_W = 20;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic load_pixel;   // capture rgb
        logic div_start;    // start the dividers
        logic search_start; // restart address counter and best-entry search
        logic search_step;  // issue read / compare
    } rhnp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic search_done;
    } rhnp_sts_t;
endpackage

// ===== hdl/rhnp_ram.sv =====
// Generic single-port-write, registered-read RAM
module rhnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/rhnp_datapath.sv =====
// Datapath: RGB to HSL conversion with serial dividers and palette search
module rhnp_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rhnp_pkg::rhnp_cmd_t  cmd,
    output rhnp_pkg::rhnp_sts_t  sts,
    input  logic                 pal_we,
    input  logic [7:0]           pal_waddr,
    input  logic [22:0]          pal_wdata,
    input  logic [7:0]           red,
    input  logic [7:0]           green,
    input  logic [7:0]           blue,
    output logic [7:0]           nearest_index,
    output logic [8:0]           hue_out,
    output logic [6:0]           saturation_out,
    output logic [6:0]           lightness_out
);
    import rhnp_pkg::*;

    logic [7:0] r_reg, g_reg, b_reg;
    logic [7:0] mx, mn, d;
    logic [8:0] sum;
    logic [8:0] den;
    logic       dzero;
    // numerators: saturation 100*d <= 25500, hue <= 360*d <= 91800
    logic [16:0] hnum;
    logic [14:0] snum;
    logic [15:0] lnum;

    // serial restoring dividers, one quotient bit per cycle
    logic [16:0] hq_reg, hq_next;
    logic [8:0]  hr_reg, hr_next;
    logic [14:0] sq_reg, sq_next;
    logic [8:0]  sr_reg, sr_next;
    logic [4:0]  dcnt_reg;
    logic        dbusy_reg;
    logic [6:0]  l_reg;

    logic [PAL_AW-1:0] raddr_reg;
    logic [PAL_CW-1:0] scnt_reg;
    logic              rvalid_reg;
    logic [PAL_AW-1:0] ridx_reg;
    logic [22:0]       rdata;
    logic [DIST_W-1:0] best_reg;
    logic [PAL_AW-1:0] besti_reg;
    logic              first_reg;
    logic              sactive_reg;
    logic              issue;
    logic [9:0]        dh, ds, dl;
    logic [DIST_W-1:0] dist_val;

    // max, min and numerators from the captured color
    always_comb begin
        mx = r_reg;
        if (g_reg > mx) mx = g_reg;
        if (b_reg > mx) mx = b_reg;
        mn = r_reg;
        if (g_reg < mn) mn = g_reg;
        if (b_reg < mn) mn = b_reg;
        d = mx - mn;
        dzero = (d == 8'd0);
        sum = {1'b0, mx} + {1'b0, mn};
        den = (sum > 9'd255) ? (9'd510 - sum) : sum;
        snum = 15'(d) * 15'd100;
        lnum = 16'(sum) * 16'd100;
        if (mx == r_reg) begin
            if (g_reg >= b_reg) hnum = 17'd60 * 17'(g_reg - b_reg);
            else hnum = 17'd360 * 17'(d) - 17'd60 * 17'(b_reg - g_reg);
        end else if (mx == g_reg) begin
            hnum = 17'd120 * 17'(d) + 17'd60 * 17'(b_reg) - 17'd60 * 17'(r_reg);
        end else begin
            hnum = 17'd240 * 17'(d) + 17'd60 * 17'(r_reg) - 17'd60 * 17'(g_reg);
        end
    end

    // one restoring step for each divider
    always_comb begin
        logic [9:0] ht, st;
        ht = {hr_reg, hq_reg[16]};
        hq_next = {hq_reg[15:0], 1'b0};
        if (ht >= {2'b0, d}) begin
            hr_next = 9'(ht - {2'b0, d});
            hq_next[0] = 1'b1;
        end else begin
            hr_next = ht[8:0];
        end
        st = {sr_reg, sq_reg[14]};
        sq_next = {sq_reg[13:0], 1'b0};
        if (st >= {1'b0, den}) begin
            sr_next = 9'(st - {1'b0, den});
            sq_next[0] = 1'b1;
        end else begin
            sr_next = st[8:0];
        end
    end

    // capture pixel and iterate dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg  <= '0;
        end else if (cmd.div_start) begin
            dbusy_reg <= !dzero;
            dcnt_reg  <= 5'd17;
            hq_reg <= dzero ? 17'd0 : hnum;
            hr_reg <= '0;
            sq_reg <= dzero ? 15'd0 : snum;
            sr_reg <= '0;
            // lightness: (sum*100)/510 via reciprocal ceil(2^24/510), exact for sum<=510
            l_reg <= 7'((32'(lnum) * 32'd32897) >> 24);
        end else if (dbusy_reg) begin
            hq_reg <= hq_next;
            hr_reg <= hr_next;
            if (dcnt_reg > 5'd2) begin
                sq_reg <= sq_next;
                sr_reg <= sr_next;
            end
            dcnt_reg <= dcnt_reg - 5'd1;
            if (dcnt_reg == 5'd1) dbusy_reg <= 1'b0;
        end
        if (cmd.load_pixel) begin
            r_reg <= red;
            g_reg <= green;
            b_reg <= blue;
        end
    end

    assign sts.div_done = !dbusy_reg && !cmd.div_start;

    rhnp_ram #(.WIDTH(ENTRY_W), .DEPTH(PALETTE_ENTRIES)) u_ram (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (PAL_AW'(pal_waddr)),
        .wdata (pal_wdata),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    // distance of the word read last cycle
    always_comb begin
        dh = (hq_reg[8:0] > rdata[22:14]) ? 10'(hq_reg[8:0] - rdata[22:14])
                                          : 10'(rdata[22:14] - hq_reg[8:0]);
        ds = (sq_reg[6:0] > rdata[13:7]) ? 10'(sq_reg[6:0] - rdata[13:7])
                                         : 10'(rdata[13:7] - sq_reg[6:0]);
        dl = (l_reg > rdata[6:0]) ? 10'(l_reg - rdata[6:0]) : 10'(rdata[6:0] - l_reg);
        dist_val = DIST_W'(dh) * DIST_W'(dh) + DIST_W'(ds) * DIST_W'(ds)
                 + DIST_W'(dl) * DIST_W'(dl);
    end

    // issue a read while entries remain
    assign issue = !cmd.search_start && sactive_reg && cmd.search_step
                   && (scnt_reg < PAL_CW'(PALETTE_ENTRIES));

    // sweep addresses and keep the best entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sactive_reg <= 1'b0;
            rvalid_reg  <= 1'b0;
            scnt_reg    <= '0;
            raddr_reg   <= '0;
        end else begin
            rvalid_reg <= issue;
            if (cmd.search_start) begin
                sactive_reg <= 1'b1;
                scnt_reg    <= '0;
                raddr_reg   <= '0;
                first_reg   <= 1'b1;
            end else if (issue) begin
                ridx_reg   <= raddr_reg;
                raddr_reg  <= raddr_reg + 1'b1;
                scnt_reg   <= scnt_reg + 1'b1;
            end else if (sactive_reg && cmd.search_step && !rvalid_reg) begin
                sactive_reg <= 1'b0;
            end
            if (!cmd.search_start && rvalid_reg && (first_reg || dist_val < best_reg)) begin
                best_reg  <= dist_val;
                besti_reg <= ridx_reg;
                first_reg <= 1'b0;
            end
        end
    end

    assign sts.search_done = !sactive_reg && !cmd.search_start;

    assign nearest_index  = 8'(besti_reg);
    assign hue_out        = hq_reg[8:0];
    assign saturation_out = sq_reg[6:0];
    assign lightness_out  = l_reg;
endmodule

// ===== hdl/rhnp_ctrl.sv =====
// Controller: sequences capture, division, search and result delivery
module rhnp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_op,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                pal_we,
    output rhnp_pkg::rhnp_cmd_t cmd,
    input  rhnp_pkg::rhnp_sts_t sts
);
    import rhnp_pkg::*;

    typedef enum logic [2:0] {IDLE, START, DIV, SEARCH, OUT} state_t;
    state_t state_reg;
    logic   mvalid_reg;

    // hold state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                IDLE: begin
                    if (s_valid && s_op == OP_PIXEL) state_reg <= START;
                end
                START: state_reg <= DIV;
                DIV: begin
                    if (sts.div_done) state_reg <= SEARCH;
                end
                SEARCH: begin
                    if (sts.search_done) begin
                        state_reg  <= OUT;
                        mvalid_reg <= 1'b1;
                    end
                end
                OUT: begin
                    if (m_ready) begin
                        state_reg  <= IDLE;
                        mvalid_reg <= 1'b0;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    // decode commands from state
    always_comb begin
        cmd = '0;
        s_ready = (state_reg == IDLE);
        pal_we = s_ready && s_valid && (s_op == OP_LOAD);
        cmd.load_pixel = s_ready && s_valid && (s_op == OP_PIXEL);
        cmd.div_start = (state_reg == START);
        cmd.search_start = (state_reg == DIV) && sts.div_done;
        cmd.search_step = (state_reg == SEARCH);
    end

    assign m_valid = mvalid_reg;
endmodule

// ===== hdl/rgb_to_hsl_nearest_palette.sv =====
// After a pixel word is accepted, the block captures it, runs the dividers (a gray
// pixel skips the 17 divider steps), then searches the palette and raises m_valid.
// The search reads one palette entry per cycle; one pixel word at a time, the next
// word is accepted in the cycle after the result word is taken.
// Load words give no result.
// Synchronous active-low reset clears control; palette contents are kept.
module rgb_to_hsl_nearest_palette (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_op,
    input  logic [7:0] s_red,
    input  logic [7:0] s_green,
    input  logic [7:0] s_blue,
    input  logic [7:0] s_entry_index,
    input  logic [8:0] s_entry_hue,
    input  logic [6:0] s_entry_saturation,
    input  logic [6:0] s_entry_lightness,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_nearest_index,
    output logic [8:0] m_hue_out,
    output logic [6:0] m_saturation_out,
    output logic [6:0] m_lightness_out
);
    import rhnp_pkg::*;
    `include "assert_macros.svh"

    rhnp_cmd_t cmd;
    rhnp_sts_t sts;
    logic      pal_we_raw;
    logic      pal_we;

    rhnp_ctrl u_ctrl (
        .aclk (aclk), .aresetn (aresetn),
        .s_valid (s_valid), .s_op (s_op), .s_ready (s_ready),
        .m_valid (m_valid), .m_ready (m_ready),
        .pal_we (pal_we_raw), .cmd (cmd), .sts (sts)
    );

    // drop loads beyond the palette
    assign pal_we = pal_we_raw && (32'(s_entry_index) < 32'(PALETTE_ENTRIES));

    rhnp_datapath u_dp (
        .aclk (aclk), .aresetn (aresetn), .cmd (cmd), .sts (sts),
        .pal_we (pal_we), .pal_waddr (s_entry_index),
        .pal_wdata ({s_entry_hue, s_entry_saturation, s_entry_lightness}),
        .red (s_red), .green (s_green), .blue (s_blue),
        .nearest_index (m_nearest_index), .hue_out (m_hue_out),
        .saturation_out (m_saturation_out), .lightness_out (m_lightness_out)
    );

    `ASSERT_IMPL(a_no_ready_while_out, aclk, aresetn, !(m_valid && s_ready))
    `ASSERT_IMPL(a_start_excl, aclk, aresetn, !(cmd.div_start && cmd.search_step))
    `ASSERT_IN_RESET(a_mvalid_reset, aclk, aresetn, m_valid)
endmodule
